@@ hw/rtl/ira_pkg.sv @@
// Shared types, constants and helpers for the integer to radix ASCII converter.
// No dependencies.
package ira_pkg;

   localparam int NUMBER_WIDTH = 64;
   localparam int VALUE_WIDTH  = 64;
   localparam int RADIX_WIDTH  = 6;
   localparam int CHAR_WIDTH   = 7;
   localparam int DIGIT_WIDTH  = 6;
   localparam int STORE_DEPTH  = NUMBER_WIDTH;
   localparam int INDEX_WIDTH  = $clog2(STORE_DEPTH);
   localparam int COUNT_WIDTH  = INDEX_WIDTH + 1;
   localparam int BIT_WIDTH    = $clog2(NUMBER_WIDTH);

   localparam logic [RADIX_WIDTH-1:0] MIN_BASE    = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] MAX_BASE    = RADIX_WIDTH'(35);
   localparam logic [RADIX_WIDTH-1:0] BINARY_BASE = RADIX_WIDTH'(2);

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(8'h30);
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER = CHAR_WIDTH'(8'h41);
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(8'h2D);
   localparam logic [CHAR_WIDTH-1:0] ASCII_NONE  = CHAR_WIDTH'(0);
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_DIGITS = DIGIT_WIDTH'(10);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MINUS,
      ST_DIV,
      ST_DIGIT,
      ST_READ,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_ZERO,
      EMIT_BAD,
      EMIT_MINUS,
      EMIT_DIGIT
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     start_digit;
      logic     div_step;
      logic     read;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic zero_case;
      logic bad_case;
      logic negative;
      logic quot_zero;
      logic bit_done;
      logic count_zero;
   } status_type;

   // Map a digit value to 0-9 then A-Z; values past the alphabet give '0'.
   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < DECIMAL_DIGITS) begin
         c = ASCII_ZERO + CHAR_WIDTH'(d);
      end else if (d <= DIGIT_WIDTH'(MAX_BASE)) begin
         c = ASCII_UPPER + CHAR_WIDTH'(d - DECIMAL_DIGITS);
      end else begin
         c = ASCII_ZERO;
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/integer_to_radix_ascii.sv @@
// Zero or a bad base gives a single result item after the operand capture; otherwise each
// digit is formed by the bit-serial divider, then the characters are sent out of the
// digit store, after a minus sign for a negative value.
// One item at a time: busy is high from acceptance until the last character is issued.
// Reset (synchronous, active high) returns the sequencer to idle and clears the strobe;
// the receiver cannot stall, each result stands on the rsp_ ports for one cycle.
module integer_to_radix_ascii (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ira_pkg::RADIX_WIDTH-1:0]        req_radix,
   input  logic signed [ira_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   output logic [ira_pkg::CHAR_WIDTH-1:0]         rsp_character,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_radix
);
   import ira_pkg::*;

   cmd_type    cmd;
   status_type status;

   ira_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ira_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_radix     (req_radix),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

endmodule

@@ hw/rtl/ira_ctrl.sv @@
// Sequencer for the radix converter: special cases, division loop, digit readout.
// Depends on ira_pkg.
module ira_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ira_pkg::status_type status,
   output ira_pkg::cmd_type    cmd
);
   import ira_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.start_digit = 1'b0;
      cmd.div_step    = 1'b0;
      cmd.read        = 1'b0;
      cmd.emit        = EMIT_NONE;
      busy            = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.zero_case) begin
               cmd.emit = EMIT_ZERO;
               state_in = ST_IDLE;
            end else if (status.bad_case) begin
               cmd.emit = EMIT_BAD;
               state_in = ST_IDLE;
            end else if (status.negative) begin
               state_in = ST_MINUS;
            end else begin
               cmd.start_digit = 1'b1;
               state_in        = ST_DIV;
            end
         end
         ST_MINUS: begin
            cmd.emit        = EMIT_MINUS;
            cmd.start_digit = 1'b1;
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.bit_done) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.quot_zero) begin
               state_in = ST_READ;
            end else begin
               cmd.start_digit = 1'b1;
               state_in        = ST_DIV;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            cmd.emit = EMIT_DIGIT;
            state_in = status.count_zero ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/ira_dp.sv @@
// Datapath: operand capture, bit-serial restoring divider, digit store, result register.
// Depends on ira_pkg.
module ira_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ira_pkg::cmd_type                      cmd,
   output ira_pkg::status_type                   status,
   input  logic [ira_pkg::RADIX_WIDTH-1:0]       req_radix,
   input  logic signed [ira_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   output logic [ira_pkg::CHAR_WIDTH-1:0]        rsp_character,
   output logic                                  rsp_last,
   output logic                                  rsp_bad_radix
);
   import ira_pkg::*;

   logic [RADIX_WIDTH-1:0]  radix_ff;
   logic [NUMBER_WIDTH-1:0] mag_ff;
   logic [DIGIT_WIDTH-1:0]  rem_ff, rem_in;
   logic [BIT_WIDTH-1:0]    bit_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic                    zero_ff, bad_ff, neg_ff;
   logic [DIGIT_WIDTH-1:0]  rd_ff;
   logic [DIGIT_WIDTH-1:0]  store [STORE_DEPTH];

   logic                    valid_ff;
   logic [CHAR_WIDTH-1:0]   char_ff;
   logic                    last_ff, badr_ff;

   logic [NUMBER_WIDTH-1:0] val_low;
   logic                    val_neg;
   logic [DIGIT_WIDTH:0]    shifted;
   logic                    qbit;
   logic [COUNT_WIDTH-1:0]  count_dec;

   assign val_low   = req_value[NUMBER_WIDTH-1:0];
   assign val_neg   = val_low[NUMBER_WIDTH-1] && (req_radix != BINARY_BASE);
   assign shifted   = {rem_ff, mag_ff[NUMBER_WIDTH-1]};
   assign qbit      = (shifted >= (DIGIT_WIDTH+1)'(radix_ff));
   assign rem_in    = qbit ? DIGIT_WIDTH'(shifted - (DIGIT_WIDTH+1)'(radix_ff))
                           : DIGIT_WIDTH'(shifted);
   assign count_dec = count_ff - COUNT_WIDTH'(1);

   // operand capture and divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radix_ff <= req_radix;
         mag_ff   <= val_neg ? (NUMBER_WIDTH'(0) - val_low) : val_low;
         neg_ff   <= val_neg;
         zero_ff  <= (val_low == '0) || (req_radix == '0);
         bad_ff   <= (req_radix < MIN_BASE) || (req_radix > MAX_BASE);
      end else if (cmd.div_step) begin
         mag_ff <= {mag_ff[NUMBER_WIDTH-2:0], qbit};
      end
      if (cmd.start_digit) begin
         rem_ff <= '0;
         bit_ff <= BIT_WIDTH'(NUMBER_WIDTH - 1);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - BIT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.div_step && (bit_ff == '0)) begin
         count_ff <= count_ff + COUNT_WIDTH'(1);
      end else if (cmd.read) begin
         count_ff <= count_dec;
      end
   end

   // digit store, least significant digit at index zero
   always_ff @(posedge clock) begin
      if (cmd.div_step && (bit_ff == '0)) begin
         store[count_ff[INDEX_WIDTH-1:0]] <= rem_in;
      end
      if (cmd.read) begin
         rd_ff <= store[count_dec[INDEX_WIDTH-1:0]];
      end
   end

   // result register, one strobe cycle per item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (cmd.emit != EMIT_NONE);
      end
      case (cmd.emit)
         EMIT_ZERO: begin
            char_ff <= ASCII_ZERO;
            last_ff <= 1'b1;
            badr_ff <= 1'b0;
         end
         EMIT_BAD: begin
            char_ff <= ASCII_NONE;
            last_ff <= 1'b1;
            badr_ff <= 1'b1;
         end
         EMIT_MINUS: begin
            char_ff <= ASCII_MINUS;
            last_ff <= 1'b0;
            badr_ff <= 1'b0;
         end
         EMIT_DIGIT: begin
            char_ff <= digit_to_ascii(rd_ff);
            last_ff <= (count_ff == '0);
            badr_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign status.zero_case  = zero_ff;
   assign status.bad_case   = bad_ff;
   assign status.negative   = neg_ff;
   assign status.quot_zero  = (mag_ff == '0);
   assign status.bit_done   = (bit_ff == '0);
   assign status.count_zero = (count_ff == '0);

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_bad_radix = badr_ff;

endmodule

@@ hw/rtl/ira_checker.sv @@
// Port-level checks for the radix converter, bound to the top level.
// Depends on ira_pkg and integer_to_radix_ascii.
module ira_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [ira_pkg::CHAR_WIDTH-1:0]  rsp_character,
   input logic                            rsp_last,
   input logic                            rsp_bad_radix
);
   import ira_pkg::*;

   // an error item is a lone, empty character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last && (rsp_character == ASCII_NONE))
      else $error("bad radix item not final or not empty");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // a conversion cannot end while characters are still owed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final item while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("item directly after final item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_radix |-> (rsp_character != ASCII_NONE))
      else $error("empty character on good item");

endmodule

bind integer_to_radix_ascii ira_checker u_ira_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last),
   .rsp_bad_radix (rsp_bad_radix)
);
